// ----- src/sti_pkg.sv -----
// Shared types and constants for the sorted key/value table.
// Holds transfer payload structs, status codes and cell control struct; no dependencies.
package sti_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int KEY_WIDTH_DEFAULT   = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_UPDATED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] entry_count;
  } result_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;    // register compare flags against the held key
    logic apply_en;  // commit the update or insert
    logic update;    // key found: overwrite the matching value
    logic insert;    // key new and room left: open a slot
  } cell_ctl_t;

endpackage

// ----- src/sorted_table_insert.sv -----
// A result is registered on leaving S_APPLY; while the output is stalled the block waits in S_APPLY.
// Items are handled one at a time: capture, registered compare in every cell, then commit.
// All cells compare and shift in parallel, so the time per item does not depend on table fill.
// Reset: synchronous, active high; empties the table and drops result valid.
// Stored keys and values are not reset; only slots marked valid are ever compared.
module sorted_table_insert #(
  parameter int DEPTH       = sti_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = sti_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = sti_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sti_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sti_pkg::result_t result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [CW-1:0]          used_count;
  logic [CW-1:0]          used_count_next;

  sti_pkg::cell_ctl_t ctl;

  // Per-cell outputs; the chain reads each at a fixed neighbor position.
  logic [DEPTH-1:0]       valid_v;
  logic [DEPTH-1:0]       lt_v;
  logic [DEPTH-1:0]       eq_v;
  logic [DEPTH-1:0]       hit_v;
  logic [KEY_WIDTH-1:0]   key_a   [DEPTH];
  logic [VALUE_WIDTH-1:0] value_a [DEPTH];

  logic          any_eq;
  logic          full;
  logic          out_free;
  logic [IW-1:0] hit_pos;
  logic [1:0]    status_next;
  logic [IW-1:0] pos_next;

  // Encode the one-hot match/insert marker into a slot index.
  function automatic logic [IW-1:0] encode(input logic [DEPTH-1:0] hot);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hot[i]) begin
        idx = idx | IW'(i);
      end
    end
    return idx;
  endfunction

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;

  // Only the boundary cell can match, so this OR sees at most one bit.
  assign any_eq  = |eq_v;
  assign full    = (used_count == CW'(DEPTH));
  assign hit_pos = encode(hit_v);

  assign ctl.cmp_en   = (state == S_CMP);
  assign ctl.apply_en = (state == S_APPLY) && out_free;
  assign ctl.update   = any_eq;
  assign ctl.insert   = !any_eq && !full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        // Hold until the result register can take the new result.
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    used_count_next = used_count;
    pos_next        = hit_pos;
    if (any_eq) begin
      status_next = sti_pkg::ST_UPDATED;
    end else if (full) begin
      status_next = sti_pkg::ST_FULL;
      pos_next    = '0;
    end else begin
      status_next     = sti_pkg::ST_INSERTED;
      used_count_next = used_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.apply_en) begin
        used_count   <= used_count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Capture the item on transfer; trim or extend to the stored widths.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      key_r   <= KEY_WIDTH'(item.key);
      value_r <= VALUE_WIDTH'(item.value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply_en) begin
      result.status      <= status_next;
      result.position    <= 6'(pos_next);
      result.entry_count <= 7'(used_count_next);
    end
  end

  // Chain of cells; slot 0 sees a left neighbor that is always below the key.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   left_lt;
    logic                   left_valid;
    logic [KEY_WIDTH-1:0]   left_key;
    logic [VALUE_WIDTH-1:0] left_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_valid = 1'b0;
      assign left_key   = '0;
      assign left_value = '0;
    end else begin : g_rest
      assign left_lt    = lt_v[i-1];
      assign left_valid = valid_v[i-1];
      assign left_key   = key_a[i-1];
      assign left_value = value_a[i-1];
    end

    sti_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_key   (key_r),
      .new_value (value_r),
      .left_lt   (left_lt),
      .left_valid(left_valid),
      .left_key  (left_key),
      .left_value(left_value),
      .valid     (valid_v[i]),
      .key       (key_a[i]),
      .value     (value_a[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i]),
      .hit       (hit_v[i])
    );
  end

endmodule

// ----- src/sti_cell.sv -----
// One slot of the sorted table: key, value, valid flag and compare flags.
// Depends on sti_pkg for the control struct; shifts from its lower neighbor on insert.
module sti_cell #(
  parameter int KEY_WIDTH   = sti_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = sti_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sti_pkg::cell_ctl_t     ctl,
  input  logic [KEY_WIDTH-1:0]   new_key,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic                   left_lt,
  input  logic                   left_valid,
  input  logic [KEY_WIDTH-1:0]   left_key,
  input  logic [VALUE_WIDTH-1:0] left_value,
  output logic                   valid,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   lt,
  output logic                   eq,
  output logic                   hit
);

  logic above;

  // First slot whose key is not below the new key: match or insert point.
  assign hit   = !lt && left_lt;
  assign above = !left_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        lt <= valid && (key < new_key);
        eq <= valid && (key == new_key);
      end
      if (ctl.apply_en && ctl.insert) begin
        if (hit) begin
          valid <= 1'b1;
        end else if (above) begin
          valid <= left_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply_en) begin
      if (ctl.update && eq) begin
        value <= new_value;
      end else if (ctl.insert && hit) begin
        key   <= new_key;
        value <= new_value;
      end else if (ctl.insert && above) begin
        key   <= left_key;
        value <= left_value;
      end
    end
  end

endmodule

// ----- src/sti_checker.sv -----
// Port-level checks for sorted_table_insert, attached by the bind below.
// Depends on sti_pkg for payload types and status codes.
module sti_checker #(
  parameter int DEPTH = sti_pkg::DEPTH_DEFAULT
) (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input sti_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input sti_pkg::result_t result
);

  localparam bit SMALL = (DEPTH <= 64);

  // Stalled result must hold.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // One item at a time: no transfer right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while busy");

  // Full reports slot zero and a full count.
  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == sti_pkg::ST_FULL |->
      result.position == 6'd0 && result.entry_count == 7'(DEPTH))
    else $error("full result has bad fields");

  // For DEPTH up to 64, an inserted entry lies inside the table.
  a_insert_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == sti_pkg::ST_INSERTED |->
      !SMALL || (result.entry_count != 7'd0 &&
                 7'(result.position) < result.entry_count))
    else $error("insert position outside table");

  // For DEPTH up to 64, an updated entry lies inside the table.
  a_update_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == sti_pkg::ST_UPDATED |->
      !SMALL || 7'(result.position) < result.entry_count)
    else $error("update position outside table");

endmodule

bind sorted_table_insert sti_checker #(.DEPTH(DEPTH)) u_sti_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
